@@ rtl/core/tpbc_pkg.sv @@
// Shared types and constants for the torch PWM and burst controller.
// Used by tpbc_duty and torch_pwm_burst_controller_unit; no dependencies.
package tpbc_pkg;

	localparam int TIMER_BITS_DEFAULT = 24;

	localparam int PERIOD_W = 16;
	localparam int BRIGHT_W = 8;
	localparam int BURST_W  = 24;
	localparam int LEN_W    = 17;
	localparam int PROD_W   = PERIOD_W + BRIGHT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Exact floor(x / 249) for any x below 2**24 as (x * DUTY_RECIP) >> DUTY_SHIFT.
	localparam int DUTY_DIV   = 249;
	localparam int DUTY_SHIFT = 32;
	localparam int RECIP_W    = 25;
	localparam logic [RECIP_W-1:0] DUTY_RECIP =
		RECIP_W'(((64'd1 << DUTY_SHIFT) + 64'(DUTY_DIV) - 64'd1) / 64'(DUTY_DIV));

	localparam logic [BRIGHT_W-1:0] BURST_LEVEL = 8'd250;
	localparam logic [BRIGHT_W-1:0] BRIGHT_OFF  = 8'd0;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_PWM   = 2'd1;
	localparam logic [1:0] MODE_BURST = 2'd2;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_BRIGHT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_PRESENT = 3'd4;

	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = 16'd100;
	localparam logic [PERIOD_W-1:0] MIN_PULSE_RST     = 16'd5;
	localparam logic [BURST_W-1:0]  BURST_HIGH_RST    = 24'd350000;
	localparam logic [BURST_W-1:0]  BURST_LOW_RST     = 24'd10000;
	localparam logic                FLASH_PRESENT_RST = 1'b1;

	typedef struct packed {
		logic                func;
		logic [BRIGHT_W-1:0] brightness;
	} in_word_t;

	typedef struct packed {
		logic       torch_level;
		logic       flash_level;
		logic [1:0] mode_now;
	} out_word_t;

endpackage

@@ rtl/core/torch_pwm_burst_controller_unit.sv @@
// Torch PWM and burst controller, top level. Depends on tpbc_pkg and tpbc_duty.
// Accepts one word per cycle unless out_stall holds the result and stalls the input.
// The first stage registers period*brightness, the second scales it, updates the
// pin state and holds it as the result. Reset clears the controller state to off
// with both pins low and loads the configuration registers with their defaults.
module torch_pwm_burst_controller_unit #(
	parameter int TIMER_BITS = tpbc_pkg::TIMER_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tpbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tpbc_pkg::in_word_t             in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tpbc_pkg::out_word_t            out_word
);

	logic [tpbc_pkg::PERIOD_W-1:0] period_q;
	logic [tpbc_pkg::PERIOD_W-1:0] min_pulse_q;
	logic [tpbc_pkg::BURST_W-1:0]  burst_high_q;
	logic [tpbc_pkg::BURST_W-1:0]  burst_low_q;
	logic                          flash_present_q;

	logic                          valid_s1;
	logic                          func_s1;
	logic [tpbc_pkg::BRIGHT_W-1:0] bright_s1;
	logic [tpbc_pkg::PROD_W-1:0]   product_s1;

	logic [1:0]                 mode_q;
	logic                       high_phase_q;
	logic [TIMER_BITS-1:0]      count_q;
	logic [tpbc_pkg::LEN_W-1:0] on_len_q;
	logic [tpbc_pkg::LEN_W-1:0] off_len_q;
	logic                       flash_pin_q;
	logic                       torch_pin_q;
	logic                       out_valid_q;

	logic [1:0]                 mode_d;
	logic                       high_phase_d;
	logic [TIMER_BITS-1:0]      count_d;
	logic [tpbc_pkg::LEN_W-1:0] on_len_d;
	logic [tpbc_pkg::LEN_W-1:0] off_len_d;
	logic                       flash_pin_d;
	logic                       torch_pin_d;

	logic [tpbc_pkg::LEN_W-1:0] calc_on;
	logic [tpbc_pkg::LEN_W-1:0] calc_off;
	logic [31:0]                burst_high_wide;
	logic [31:0]                burst_low_wide;
	logic [TIMER_BITS-1:0]      burst_high_load;
	logic [TIMER_BITS-1:0]      burst_low_load;
	logic                       phase_end;
	logic                       advance;
	logic                       load_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q        <= tpbc_pkg::PWM_PERIOD_RST;
			min_pulse_q     <= tpbc_pkg::MIN_PULSE_RST;
			burst_high_q    <= tpbc_pkg::BURST_HIGH_RST;
			burst_low_q     <= tpbc_pkg::BURST_LOW_RST;
			flash_present_q <= tpbc_pkg::FLASH_PRESENT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tpbc_pkg::REG_PWM_PERIOD: period_q <= cfg_data[tpbc_pkg::PERIOD_W-1:0];
				tpbc_pkg::REG_MIN_PULSE: min_pulse_q <= cfg_data[tpbc_pkg::PERIOD_W-1:0];
				tpbc_pkg::REG_BURST_HIGH: burst_high_q <= cfg_data[tpbc_pkg::BURST_W-1:0];
				tpbc_pkg::REG_BURST_LOW: burst_low_q <= cfg_data[tpbc_pkg::BURST_W-1:0];
				tpbc_pkg::REG_FLASH_PRESENT: flash_present_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: stage two advances when it holds a word and the result is free.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			func_s1    <= in_word.func;
			bright_s1  <= in_word.brightness;
			product_s1 <= tpbc_pkg::PROD_W'(period_q) * tpbc_pkg::PROD_W'(in_word.brightness);
		end
	end

	tpbc_duty u_duty (
		.product   (product_s1),
		.period    (period_q),
		.min_pulse (min_pulse_q),
		.on_len    (calc_on),
		.off_len   (calc_off)
	);

	assign burst_high_wide = 32'(burst_high_q);
	assign burst_low_wide  = 32'(burst_low_q);
	assign burst_high_load = burst_high_wide[TIMER_BITS-1:0];
	assign burst_low_load  = burst_low_wide[TIMER_BITS-1:0];
	assign phase_end       = (count_q < TIMER_BITS'(2));

	always_comb begin
		mode_d       = mode_q;
		high_phase_d = high_phase_q;
		count_d      = count_q;
		on_len_d     = on_len_q;
		off_len_d    = off_len_q;
		flash_pin_d  = flash_pin_q;
		torch_pin_d  = torch_pin_q;
		if (func_s1 == tpbc_pkg::FUNC_BRIGHT) begin
			priority if (bright_s1 == tpbc_pkg::BRIGHT_OFF) begin
				mode_d       = tpbc_pkg::MODE_OFF;
				torch_pin_d  = 1'b0;
				flash_pin_d  = 1'b0;
				high_phase_d = 1'b0;
				count_d      = '0;
			end else if (bright_s1 >= tpbc_pkg::BURST_LEVEL) begin
				mode_d       = tpbc_pkg::MODE_BURST;
				torch_pin_d  = 1'b1;
				high_phase_d = 1'b0;
				flash_pin_d  = flash_present_q;
				count_d      = flash_present_q ? burst_high_load : '0;
			end else begin
				on_len_d    = calc_on;
				off_len_d   = calc_off;
				flash_pin_d = 1'b0;
				if (mode_q != tpbc_pkg::MODE_PWM) begin
					mode_d       = tpbc_pkg::MODE_PWM;
					torch_pin_d  = 1'b1;
					high_phase_d = 1'b1;
					count_d      = TIMER_BITS'(calc_on);
				end
			end
		end else begin
			if (mode_q == tpbc_pkg::MODE_PWM) begin
				if (!phase_end) begin
					count_d = count_q - TIMER_BITS'(1);
				end else if (high_phase_q) begin
					high_phase_d = 1'b0;
					torch_pin_d  = 1'b0;
					count_d      = TIMER_BITS'(off_len_q);
				end else begin
					high_phase_d = 1'b1;
					torch_pin_d  = 1'b1;
					count_d      = TIMER_BITS'(on_len_q);
				end
			end else if (mode_q == tpbc_pkg::MODE_BURST) begin
				if (!flash_present_q) begin
					flash_pin_d = 1'b0;
				end else if (!phase_end) begin
					count_d = count_q - TIMER_BITS'(1);
				end else if (flash_pin_q) begin
					flash_pin_d = 1'b0;
					count_d     = burst_low_load;
				end else begin
					flash_pin_d = 1'b1;
					count_d     = burst_high_load;
				end
			end
		end
	end

	// Controller state; the pin and mode registers double as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= tpbc_pkg::MODE_OFF;
			high_phase_q <= 1'b0;
			count_q      <= '0;
			on_len_q     <= '0;
			off_len_q    <= '0;
			flash_pin_q  <= 1'b0;
			torch_pin_q  <= 1'b0;
		end else if (advance) begin
			mode_q       <= mode_d;
			high_phase_q <= high_phase_d;
			count_q      <= count_d;
			on_len_q     <= on_len_d;
			off_len_q    <= off_len_d;
			flash_pin_q  <= flash_pin_d;
			torch_pin_q  <= torch_pin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign out_word.torch_level = torch_pin_q;
	assign out_word.flash_level = flash_pin_q;
	assign out_word.mode_now    = mode_q;

endmodule

@@ rtl/core/tpbc_duty.sv @@
// PWM phase length calculation: scales period*brightness by 1/249 and applies
// the minimum pulse floor to both phases. Depends on tpbc_pkg.
module tpbc_duty (
	input  logic [tpbc_pkg::PROD_W-1:0]   product,
	input  logic [tpbc_pkg::PERIOD_W-1:0] period,
	input  logic [tpbc_pkg::PERIOD_W-1:0] min_pulse,
	output logic [tpbc_pkg::LEN_W-1:0]    on_len,
	output logic [tpbc_pkg::LEN_W-1:0]    off_len
);

	localparam int SCALED_W = tpbc_pkg::PROD_W + tpbc_pkg::RECIP_W;

	logic [SCALED_W-1:0]         scaled;
	logic [tpbc_pkg::LEN_W-1:0] quotient;
	logic [tpbc_pkg::LEN_W-1:0] period_ext;
	logic [tpbc_pkg::LEN_W-1:0] min_ext;
	logic [tpbc_pkg::LEN_W-1:0] rest;

	assign scaled     = SCALED_W'(product) * SCALED_W'(tpbc_pkg::DUTY_RECIP);
	assign quotient   = scaled[tpbc_pkg::DUTY_SHIFT +: tpbc_pkg::LEN_W];
	assign period_ext = tpbc_pkg::LEN_W'(period);
	assign min_ext    = tpbc_pkg::LEN_W'(min_pulse);

	always_comb begin
		on_len = (quotient < min_ext) ? min_ext : quotient;
		rest = (period_ext > on_len) ? (period_ext - on_len) : '0;
		off_len = (rest < min_ext) ? min_ext : rest;
	end

endmodule
